// File: rtl/core/wshrm_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package wshrm_pkg;

   // Default depth of the heart rate history.
   localparam int HISTORY_DEPTH_DEFAULT = 30;

   // Fixed thresholds of the classifier.
   localparam int MIN_FILLED      = 10;
   localparam int LOST_TIMEOUT_MS = 10000;
   localparam int SPREAD_SQ       = 25;

   // Configuration port geometry.
   localparam int CSR_ADDR_W = 5;
   localparam int CSR_DATA_W = 32;
   localparam int DEV_W      = 7;

   // Register indexes.
   localparam logic [2:0] REG_FAST_RATE     = 3'd0;
   localparam logic [2:0] REG_SLOW_RATE     = 3'd1;
   localparam logic [2:0] REG_DEVIATION     = 3'd2;
   localparam logic [2:0] REG_DARK_LUX      = 3'd3;
   localparam logic [2:0] REG_SLEEP_LOW     = 3'd4;
   localparam logic [2:0] REG_SLEEP_HIGH    = 3'd5;
   localparam logic [2:0] REG_SLEEP_CONFIRM = 3'd6;
   localparam logic [2:0] REG_WAKE_CONFIRM  = 3'd7;

   // Status codes.
   localparam logic [1:0] WEAR_UNKNOWN   = 2'd0;
   localparam logic [1:0] WEAR_YES       = 2'd1;
   localparam logic [1:0] WEAR_NO        = 2'd2;
   localparam logic [1:0] SLEEP_UNKNOWN  = 2'd0;
   localparam logic [1:0] SLEEP_ASLEEP   = 2'd1;
   localparam logic [1:0] SLEEP_AWAKE    = 2'd2;
   localparam logic [1:0] HEART_NORMAL   = 2'd0;
   localparam logic [1:0] HEART_FAST     = 2'd1;
   localparam logic [1:0] HEART_SLOW     = 2'd2;
   localparam logic [1:0] HEART_UNSTABLE = 2'd3;

   typedef struct packed {
      logic [7:0]       fast_rate_limit;
      logic [7:0]       slow_rate_limit;
      logic [DEV_W-1:0] deviation_percent;
      logic [15:0]      dark_lux_limit;
      logic [7:0]       sleep_rate_low;
      logic [7:0]       sleep_rate_high;
      logic [19:0]      sleep_confirm_ms;
      logic [19:0]      wake_confirm_ms;
   } cfg_type;

   localparam cfg_type CFG_RESET = '{
      fast_rate_limit:   8'd120,
      slow_rate_limit:   8'd50,
      deviation_percent: 7'd20,
      dark_lux_limit:    16'd50,
      sleep_rate_low:    8'd50,
      sleep_rate_high:   8'd75,
      sleep_confirm_ms:  20'd30000,
      wake_confirm_ms:   20'd15000
   };

endpackage

`default_nettype wire

// File: rtl/core/wshrm_csr.sv
`timescale 1ns / 1ps
`default_nettype none

module wshrm_csr (
   input  wire logic                                clock,
   input  wire logic                                reset,
   input  wire logic                                csr_psel,
   input  wire logic                                csr_penable,
   input  wire logic                                csr_pwrite,
   input  wire logic [wshrm_pkg::CSR_ADDR_W-1:0]    csr_paddr,
   input  wire logic [wshrm_pkg::CSR_DATA_W-1:0]    csr_pwdata,
   output logic      [wshrm_pkg::CSR_DATA_W-1:0]    csr_prdata,
   output logic                                     csr_pready,
   output wshrm_pkg::cfg_type                       cfg
);

   wshrm_pkg::cfg_type cfg_ff;
   wshrm_pkg::cfg_type cfg_in;
   logic [2:0]         index;
   logic               wr_en;

   assign index      = csr_paddr[4:2];
   assign wr_en      = csr_psel & csr_penable & csr_pwrite;
   assign csr_pready = 1'b1;
   assign cfg        = cfg_ff;

   always_comb begin
      cfg_in = cfg_ff;
      if (wr_en) begin
         case (index)
            wshrm_pkg::REG_FAST_RATE:     cfg_in.fast_rate_limit   = csr_pwdata[7:0];
            wshrm_pkg::REG_SLOW_RATE:     cfg_in.slow_rate_limit   = csr_pwdata[7:0];
            wshrm_pkg::REG_DEVIATION:     cfg_in.deviation_percent = csr_pwdata[6:0];
            wshrm_pkg::REG_DARK_LUX:      cfg_in.dark_lux_limit    = csr_pwdata[15:0];
            wshrm_pkg::REG_SLEEP_LOW:     cfg_in.sleep_rate_low    = csr_pwdata[7:0];
            wshrm_pkg::REG_SLEEP_HIGH:    cfg_in.sleep_rate_high   = csr_pwdata[7:0];
            wshrm_pkg::REG_SLEEP_CONFIRM: cfg_in.sleep_confirm_ms  = csr_pwdata[19:0];
            wshrm_pkg::REG_WAKE_CONFIRM:  cfg_in.wake_confirm_ms   = csr_pwdata[19:0];
            default:                      cfg_in = cfg_ff;
         endcase
      end
   end

   always_comb begin
      case (index)
         wshrm_pkg::REG_FAST_RATE:     csr_prdata = 32'(cfg_ff.fast_rate_limit);
         wshrm_pkg::REG_SLOW_RATE:     csr_prdata = 32'(cfg_ff.slow_rate_limit);
         wshrm_pkg::REG_DEVIATION:     csr_prdata = 32'(cfg_ff.deviation_percent);
         wshrm_pkg::REG_DARK_LUX:      csr_prdata = 32'(cfg_ff.dark_lux_limit);
         wshrm_pkg::REG_SLEEP_LOW:     csr_prdata = 32'(cfg_ff.sleep_rate_low);
         wshrm_pkg::REG_SLEEP_HIGH:    csr_prdata = 32'(cfg_ff.sleep_rate_high);
         wshrm_pkg::REG_SLEEP_CONFIRM: csr_prdata = 32'(cfg_ff.sleep_confirm_ms);
         wshrm_pkg::REG_WAKE_CONFIRM:  csr_prdata = 32'(cfg_ff.wake_confirm_ms);
         default:                      csr_prdata = '0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff <= wshrm_pkg::CFG_RESET;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

endmodule

`default_nettype wire

// File: rtl/core/wshrm_ring.sv
`timescale 1ns / 1ps
`default_nettype none

module wshrm_ring #(
   parameter  int DEPTH = wshrm_pkg::HISTORY_DEPTH_DEFAULT,
   localparam int PTR_W = $clog2(DEPTH),
   localparam int CNT_W = $clog2(DEPTH + 1)
) (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             push,
   input  wire logic [7:0]       push_rate,
   output logic      [7:0]       old_rate,
   output logic      [CNT_W-1:0] fill_count,
   output logic                  full
);

   // Read-first single port memory: a push reads the slot it replaces.
   logic [7:0]       ring_ff [DEPTH];
   logic [7:0]       old_rate_ff;
   logic [PTR_W-1:0] ptr_ff;
   logic [PTR_W-1:0] ptr_in;
   logic [CNT_W-1:0] count_ff;
   logic [CNT_W-1:0] count_in;

   assign full       = (count_ff == CNT_W'(DEPTH));
   assign fill_count = count_ff;
   assign old_rate   = old_rate_ff;

   always_comb begin
      ptr_in   = ptr_ff;
      count_in = count_ff;
      if (push) begin
         ptr_in = (ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : ptr_ff + PTR_W'(1);
         if (!full) begin
            count_in = count_ff + CNT_W'(1);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         ptr_ff   <= '0;
         count_ff <= '0;
      end else begin
         ptr_ff   <= ptr_in;
         count_ff <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         old_rate_ff     <= ring_ff[ptr_ff];
         ring_ff[ptr_ff] <= push_rate;
      end
   end

endmodule

`default_nettype wire

// File: rtl/core/wear_sleep_heart_rate_monitor_top.sv
`timescale 1ns / 1ps
`default_nettype none

// Wearable monitor that takes one sensor update per beat (heart rate, link,
// presence, light, millisecond time) and returns one classification beat:
// wear status, sleep status and heart rate class. The block accepts one
// update every clock unless a stall at the result side backs up the
// stages; the single port history memory is read and written once per
// accepted update (read-first, so the replaced rate is registered as the
// new one is written). Nonzero rates enter a history ring of
// HISTORY_DEPTH entries; a running sum and a running sum of squares stand in
// for the mean and the spread, and every test is an exact integer compare.
// The pipeline has four internal stages plus an output register; when the
// result side stalls, the stages keep filling, so up to five updates may be
// in flight while a result waits. The history needs no clearing after reset:
// only slots that were written are ever read back. Timestamps wrap modulo
// 2^32, and the configuration registers (byte address 4 times the index)
// should be written only while no update is in flight.
module wear_sleep_heart_rate_monitor_top #(
   parameter int HISTORY_DEPTH = wshrm_pkg::HISTORY_DEPTH_DEFAULT
) (
   input  wire logic                                clock,
   input  wire logic                                reset,
   input  wire logic                                req_valid,
   output logic                                     req_ready,
   input  wire logic [7:0]                          req_heart_rate,
   input  wire logic                                req_link_connected,
   input  wire logic                                req_human_present,
   input  wire logic [15:0]                         req_light_lux,
   input  wire logic [31:0]                         req_now_ms,
   output logic                                     rsp_valid,
   input  wire logic                                rsp_ready,
   output logic                                     rsp_wearing_flag,
   output logic                                     rsp_sleeping_flag,
   output logic                                     rsp_heart_alert,
   output logic      [1:0]                          rsp_wear_code,
   output logic      [1:0]                          rsp_sleep_code,
   output logic      [1:0]                          rsp_heart_code,
   input  wire logic                                csr_psel,
   input  wire logic                                csr_penable,
   input  wire logic                                csr_pwrite,
   input  wire logic [wshrm_pkg::CSR_ADDR_W-1:0]    csr_paddr,
   input  wire logic [wshrm_pkg::CSR_DATA_W-1:0]    csr_pwdata,
   output logic      [wshrm_pkg::CSR_DATA_W-1:0]    csr_prdata,
   output logic                                     csr_pready
);

   // Widths follow from the history depth.
   localparam int CNT_W  = $clog2(HISTORY_DEPTH + 1);
   localparam int SUM_W  = $clog2(HISTORY_DEPTH * 255 + 1);
   localparam int SQ_W   = $clog2(HISTORY_DEPTH * 65025 + 1);
   localparam int NQ_W   = CNT_W + SQ_W;
   localparam int SS_W   = 2 * SUM_W;
   localparam int VAR_W  = (NQ_W > SS_W) ? NQ_W : SS_W;
   localparam int N2_W   = 2 * CNT_W;
   localparam int DS_W   = wshrm_pkg::DEV_W + SUM_W;
   localparam int PHR_W  = 8 + CNT_W;

   wshrm_pkg::cfg_type cfg;

   // Handshake and stage advance. Each stage moves on when the one after it
   // is empty or moving, so bubbles collapse and the input keeps flowing
   // while a finished result waits at the output.
   logic accept;
   logic push;
   logic s2_load;
   logic s3_load;
   logic s4_load;
   logic out_load;

   logic s1_valid_ff, s2_valid_ff, s3_valid_ff, s4_valid_ff, rsp_valid_ff;

   assign out_load  = s4_valid_ff & (~rsp_valid_ff | rsp_ready);
   assign s4_load   = s3_valid_ff & (~s4_valid_ff | out_load);
   assign s3_load   = s2_valid_ff & (~s3_valid_ff | s4_load);
   assign s2_load   = s1_valid_ff & (~s2_valid_ff | s3_load);
   assign req_ready = ~s1_valid_ff | s2_load;
   assign accept    = req_valid & req_ready;
   assign push      = accept & (req_heart_rate != 8'd0);
   assign rsp_valid = rsp_valid_ff;

   wshrm_csr u_csr (
      .clock       (clock),
      .reset       (reset),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready),
      .cfg         (cfg)
   );

   // The ring keeps the history, its write pointer and its fill count. A push
   // reads back the rate it overwrites; that value arrives with stage one.
   logic [7:0]       old_rate;
   logic [CNT_W-1:0] fill_count;
   logic             ring_full;

   wshrm_ring #(
      .DEPTH (HISTORY_DEPTH)
   ) u_ring (
      .clock      (clock),
      .reset      (reset),
      .push       (push),
      .push_rate  (req_heart_rate),
      .old_rate   (old_rate),
      .fill_count (fill_count),
      .full       (ring_full)
   );

   // ---------------------------------------------------------------------
   // Stage one: the accepted beat. Here the running sums, the last beat time
   // and the wear status are updated. The ring's fill count already counts
   // this beat, since nothing new is accepted until this stage moves on.
   // ---------------------------------------------------------------------
   logic [7:0]  s1_hr_ff;
   logic        s1_link_ff;
   logic        s1_present_ff;
   logic [15:0] s1_lux_ff;
   logic [31:0] s1_now_ff;
   logic        s1_replace_ff;

   logic [SUM_W-1:0] sum_ff, sum_in;
   logic [SQ_W-1:0]  sq_ff, sq_in;
   logic [31:0]      last_beat_ff, last_beat_in;
   logic             beat_seen_ff, beat_seen_in;
   logic [1:0]       wear_ff, wear_in;
   logic [15:0]      hr_sq;
   logic [15:0]      old_sq;
   logic [7:0]       old_sub;
   logic             s1_has_rate;

   assign s1_has_rate = (s1_hr_ff != 8'd0);
   assign old_sub     = s1_replace_ff ? old_rate : 8'd0;
   assign hr_sq       = s1_hr_ff * s1_hr_ff;
   assign old_sq      = old_sub * old_sub;

   always_comb begin
      sum_in       = sum_ff;
      sq_in        = sq_ff;
      last_beat_in = last_beat_ff;
      beat_seen_in = beat_seen_ff;
      wear_in      = wear_ff;
      if (s2_load) begin
         if (s1_has_rate) begin
            sum_in       = sum_ff + SUM_W'(s1_hr_ff) - SUM_W'(old_sub);
            sq_in        = sq_ff + SQ_W'(hr_sq) - SQ_W'(old_sq);
            last_beat_in = s1_now_ff;
            beat_seen_in = 1'b1;
         end
         // A missing rate only means lost once the timeout has run out; an
         // unknown status falls to not wearing as soon as a beat was seen.
         if (s1_link_ff && s1_has_rate) begin
            wear_in = wshrm_pkg::WEAR_YES;
         end else if (!s1_link_ff) begin
            wear_in = wshrm_pkg::WEAR_NO;
         end else if (!beat_seen_ff) begin
            wear_in = wshrm_pkg::WEAR_UNKNOWN;
         end else if ((s1_now_ff - last_beat_ff) >= 32'(wshrm_pkg::LOST_TIMEOUT_MS)) begin
            wear_in = wshrm_pkg::WEAR_NO;
         end else if (wear_ff == wshrm_pkg::WEAR_UNKNOWN) begin
            wear_in = wshrm_pkg::WEAR_NO;
         end
      end
   end

   // ---------------------------------------------------------------------
   // Stage two: a snapshot of count, sum and square sum after this beat.
   // All products of the mean and spread tests are formed here.
   // ---------------------------------------------------------------------
   logic [7:0]       s2_hr_ff;
   logic [CNT_W-1:0] s2_n_ff;
   logic [SUM_W-1:0] s2_sum_ff;
   logic [SQ_W-1:0]  s2_sq_ff;
   logic             s2_present_ff;
   logic [15:0]      s2_lux_ff;
   logic [31:0]      s2_now_ff;
   logic [1:0]       s2_wear_ff;

   logic [PHR_W-1:0] phr_full;
   logic [PHR_W-1:0] lown_full;
   logic [PHR_W-1:0] highn_full;
   logic [DS_W-1:0]  devs_full;
   logic [NQ_W-1:0]  nq_full;
   logic [SS_W-1:0]  ss_full;
   logic [N2_W-1:0]  n2_full;

   assign phr_full   = s2_hr_ff * s2_n_ff;
   assign lown_full  = cfg.sleep_rate_low * s2_n_ff;
   assign highn_full = cfg.sleep_rate_high * s2_n_ff;
   assign devs_full  = cfg.deviation_percent * s2_sum_ff;
   assign nq_full    = s2_n_ff * s2_sq_ff;
   assign ss_full    = s2_sum_ff * s2_sum_ff;
   assign n2_full    = s2_n_ff * s2_n_ff;

   // ---------------------------------------------------------------------
   // Stage three: deviation magnitude, mean window and spread test.
   // ---------------------------------------------------------------------
   logic [7:0]       s3_hr_ff;
   logic [CNT_W-1:0] s3_n_ff;
   logic [SUM_W-1:0] s3_sum_ff;
   logic [SUM_W-1:0] s3_phr_ff;
   logic [SUM_W-1:0] s3_lown_ff;
   logic [SUM_W-1:0] s3_highn_ff;
   logic [DS_W-1:0]  s3_devs_ff;
   logic [NQ_W-1:0]  s3_nq_ff;
   logic [SS_W-1:0]  s3_ss_ff;
   logic [N2_W-1:0]  s3_n2_ff;
   logic             s3_present_ff;
   logic [15:0]      s3_lux_ff;
   logic [31:0]      s3_now_ff;
   logic [1:0]       s3_wear_ff;

   logic [SUM_W-1:0] diff;
   logic [VAR_W-1:0] nq_ext;
   logic [VAR_W-1:0] ss_ext;
   logic [VAR_W-1:0] n2_ext;
   logic [VAR_W-1:0] spread_limit;
   logic             spread_ok;
   logic             mean_ok;
   logic             fill_ok;
   logic             dark;

   assign diff = (s3_phr_ff >= s3_sum_ff) ? s3_phr_ff - s3_sum_ff : s3_sum_ff - s3_phr_ff;
   assign nq_ext       = VAR_W'(s3_nq_ff);
   assign ss_ext       = VAR_W'(s3_ss_ff);
   assign n2_ext       = VAR_W'(s3_n2_ff);
   // Spread within five: n*q - s^2 <= 25*n^2, written as shifts and adds.
   assign spread_limit = (n2_ext << 4) + (n2_ext << 3) + n2_ext;
   assign spread_ok    = (nq_ext < ss_ext) || ((nq_ext - ss_ext) <= spread_limit);
   assign mean_ok      = (s3_lown_ff <= s3_sum_ff) && (s3_sum_ff <= s3_highn_ff);
   assign fill_ok      = (s3_n_ff >= CNT_W'(wshrm_pkg::MIN_FILLED));
   assign dark         = (s3_lux_ff < cfg.dark_lux_limit);

   // ---------------------------------------------------------------------
   // Stage four: heart class and the sleep timers, then the output register.
   // ---------------------------------------------------------------------
   logic [7:0]       s4_hr_ff;
   logic [SUM_W-1:0] s4_diff_ff;
   logic [DS_W-1:0]  s4_devs_ff;
   logic             s4_fill_ok_ff;
   logic             s4_sum_pos_ff;
   logic             s4_mean_ok_ff;
   logic             s4_spread_ok_ff;
   logic             s4_dark_ff;
   logic             s4_present_ff;
   logic [31:0]      s4_now_ff;
   logic [1:0]       s4_wear_ff;

   logic [DS_W-1:0] diff_ext;
   logic [DS_W-1:0] diff_x100;
   logic            unstable;
   logic [1:0]      heart_code;
   logic            sleep_cond;

   assign diff_ext  = DS_W'(s4_diff_ff);
   assign diff_x100 = (diff_ext << 6) + (diff_ext << 5) + (diff_ext << 2);
   assign unstable  = s4_fill_ok_ff & s4_sum_pos_ff & (diff_x100 > s4_devs_ff);
   assign sleep_cond = s4_present_ff & s4_dark_ff & s4_fill_ok_ff & s4_mean_ok_ff
                     & s4_spread_ok_ff;

   always_comb begin
      if (s4_hr_ff == 8'd0) begin
         heart_code = wshrm_pkg::HEART_NORMAL;
      end else if (s4_hr_ff > cfg.fast_rate_limit) begin
         heart_code = wshrm_pkg::HEART_FAST;
      end else if (s4_hr_ff < cfg.slow_rate_limit) begin
         heart_code = wshrm_pkg::HEART_SLOW;
      end else if (unstable) begin
         heart_code = wshrm_pkg::HEART_UNSTABLE;
      end else begin
         heart_code = wshrm_pkg::HEART_NORMAL;
      end
   end

   // Sleep timers. Entering the condition restarts the sleep timer and
   // disarms the wake timer; leaving it starts the wake timer. Before the
   // condition has ever held, the wake timer reads zero, so a zero wake time
   // reports awake at once.
   logic        sl_flag_ff, sl_flag_in;
   logic [31:0] sl_since_ff, sl_since_in;
   logic [31:0] wk_since_ff, wk_since_in;
   logic        wk_armed_ff, wk_armed_in;
   logic [1:0]  sleep_ff, sleep_in;
   logic [31:0] wake_elapsed;

   always_comb begin
      sl_flag_in   = sl_flag_ff;
      sl_since_in  = sl_since_ff;
      wk_since_in  = wk_since_ff;
      wk_armed_in  = wk_armed_ff;
      sleep_in     = sleep_ff;
      wake_elapsed = '0;
      if (out_load) begin
         if (sleep_cond) begin
            if (!sl_flag_ff) begin
               sl_flag_in  = 1'b1;
               sl_since_in = s4_now_ff;
               wk_armed_in = 1'b0;
            end
            if ((sleep_ff != wshrm_pkg::SLEEP_ASLEEP)
                && ((s4_now_ff - sl_since_in) >= 32'(cfg.sleep_confirm_ms))) begin
               sleep_in = wshrm_pkg::SLEEP_ASLEEP;
            end
         end else begin
            if (sl_flag_ff) begin
               sl_flag_in  = 1'b0;
               wk_since_in = s4_now_ff;
               wk_armed_in = 1'b1;
               sl_since_in = '0;
            end
            if (sleep_ff != wshrm_pkg::SLEEP_AWAKE) begin
               wake_elapsed = wk_armed_in ? (s4_now_ff - wk_since_in) : 32'd0;
               if (wake_elapsed >= 32'(cfg.wake_confirm_ms)) begin
                  sleep_in = wshrm_pkg::SLEEP_AWAKE;
               end
            end
         end
      end
   end

   logic [1:0] rsp_wear_ff;
   logic [1:0] rsp_sleep_ff;
   logic [1:0] rsp_heart_ff;

   assign rsp_wear_code     = rsp_wear_ff;
   assign rsp_sleep_code    = rsp_sleep_ff;
   assign rsp_heart_code    = rsp_heart_ff;
   assign rsp_wearing_flag  = (rsp_wear_ff == wshrm_pkg::WEAR_YES);
   assign rsp_sleeping_flag = (rsp_sleep_ff == wshrm_pkg::SLEEP_ASLEEP);
   assign rsp_heart_alert   = (rsp_heart_ff != wshrm_pkg::HEART_NORMAL);

   // Control and state registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         s2_valid_ff  <= 1'b0;
         s3_valid_ff  <= 1'b0;
         s4_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
         sum_ff       <= '0;
         sq_ff        <= '0;
         last_beat_ff <= '0;
         beat_seen_ff <= 1'b0;
         wear_ff      <= wshrm_pkg::WEAR_UNKNOWN;
         sl_flag_ff   <= 1'b0;
         sl_since_ff  <= '0;
         wk_since_ff  <= '0;
         wk_armed_ff  <= 1'b0;
         sleep_ff     <= wshrm_pkg::SLEEP_UNKNOWN;
      end else begin
         s1_valid_ff  <= accept | (s1_valid_ff & ~s2_load);
         s2_valid_ff  <= s2_load | (s2_valid_ff & ~s3_load);
         s3_valid_ff  <= s3_load | (s3_valid_ff & ~s4_load);
         s4_valid_ff  <= s4_load | (s4_valid_ff & ~out_load);
         rsp_valid_ff <= out_load | (rsp_valid_ff & ~rsp_ready);
         sum_ff       <= sum_in;
         sq_ff        <= sq_in;
         last_beat_ff <= last_beat_in;
         beat_seen_ff <= beat_seen_in;
         wear_ff      <= wear_in;
         sl_flag_ff   <= sl_flag_in;
         sl_since_ff  <= sl_since_in;
         wk_since_ff  <= wk_since_in;
         wk_armed_ff  <= wk_armed_in;
         sleep_ff     <= sleep_in;
      end
   end

   // Stage payload registers.
   always_ff @(posedge clock) begin
      if (accept) begin
         s1_hr_ff      <= req_heart_rate;
         s1_link_ff    <= req_link_connected;
         s1_present_ff <= req_human_present;
         s1_lux_ff     <= req_light_lux;
         s1_now_ff     <= req_now_ms;
         s1_replace_ff <= ring_full;
      end
      if (s2_load) begin
         s2_hr_ff      <= s1_hr_ff;
         s2_n_ff       <= fill_count;
         s2_sum_ff     <= sum_in;
         s2_sq_ff      <= sq_in;
         s2_present_ff <= s1_present_ff;
         s2_lux_ff     <= s1_lux_ff;
         s2_now_ff     <= s1_now_ff;
         s2_wear_ff    <= wear_in;
      end
      if (s3_load) begin
         s3_hr_ff      <= s2_hr_ff;
         s3_n_ff       <= s2_n_ff;
         s3_sum_ff     <= s2_sum_ff;
         s3_phr_ff     <= SUM_W'(phr_full);
         s3_lown_ff    <= SUM_W'(lown_full);
         s3_highn_ff   <= SUM_W'(highn_full);
         s3_devs_ff    <= devs_full;
         s3_nq_ff      <= nq_full;
         s3_ss_ff      <= ss_full;
         s3_n2_ff      <= n2_full;
         s3_present_ff <= s2_present_ff;
         s3_lux_ff     <= s2_lux_ff;
         s3_now_ff     <= s2_now_ff;
         s3_wear_ff    <= s2_wear_ff;
      end
      if (s4_load) begin
         s4_hr_ff        <= s3_hr_ff;
         s4_diff_ff      <= diff;
         s4_devs_ff      <= s3_devs_ff;
         s4_fill_ok_ff   <= fill_ok;
         s4_sum_pos_ff   <= (s3_sum_ff != '0);
         s4_mean_ok_ff   <= mean_ok;
         s4_spread_ok_ff <= spread_ok;
         s4_dark_ff      <= dark;
         s4_present_ff   <= s3_present_ff;
         s4_now_ff       <= s3_now_ff;
         s4_wear_ff      <= s3_wear_ff;
      end
      if (out_load) begin
         rsp_wear_ff  <= s4_wear_ff;
         rsp_sleep_ff <= sleep_in;
         rsp_heart_ff <= heart_code;
      end
   end

endmodule

`default_nettype wire

// File: test/wshrm_status_checker.sv
`timescale 1ns / 1ps

// Watches the update, result and register channels of the monitor, keeps its
// own copy of the classifier state and checks every result beat in order.
module wshrm_status_checker #(
   parameter int HISTORY_DEPTH = wshrm_pkg::HISTORY_DEPTH_DEFAULT
) (
   input  wire logic                             clock,
   input  wire logic                             reset,
   input  wire logic                             req_valid,
   input  wire logic                             req_ready,
   input  wire logic [7:0]                       req_heart_rate,
   input  wire logic                             req_link_connected,
   input  wire logic                             req_human_present,
   input  wire logic [15:0]                      req_light_lux,
   input  wire logic [31:0]                      req_now_ms,
   input  wire logic                             rsp_valid,
   input  wire logic                             rsp_ready,
   input  wire logic                             rsp_wearing_flag,
   input  wire logic                             rsp_sleeping_flag,
   input  wire logic                             rsp_heart_alert,
   input  wire logic [1:0]                       rsp_wear_code,
   input  wire logic [1:0]                       rsp_sleep_code,
   input  wire logic [1:0]                       rsp_heart_code,
   input  wire logic                             csr_psel,
   input  wire logic                             csr_penable,
   input  wire logic                             csr_pwrite,
   input  wire logic [wshrm_pkg::CSR_ADDR_W-1:0] csr_paddr,
   input  wire logic [wshrm_pkg::CSR_DATA_W-1:0] csr_pwdata,
   input  wire logic [wshrm_pkg::CSR_DATA_W-1:0] csr_prdata,
   input  wire logic                             csr_pready,
   output int                                    mismatch_count,
   output int                                    pending_beats,
   output int                                    checked_beats,
   output int                                    asleep_beats,
   output int                                    unstable_beats
);

   import wshrm_pkg::*;

   typedef struct packed {
      logic       wearing_flag;
      logic       sleeping_flag;
      logic       heart_alert;
      logic [1:0] wear_code;
      logic [1:0] sleep_code;
      logic [1:0] heart_code;
   } monitor_status_t;

   cfg_type         limits;
   logic [7:0]      rate_hist [HISTORY_DEPTH];
   int unsigned     hist_ptr;
   int unsigned     hist_fill;
   int unsigned     rate_sum;
   int unsigned     rate_sq_sum;
   logic [1:0]      wear_state;
   logic [1:0]      sleep_state;
   logic [1:0]      heart_state;
   logic [31:0]     last_beat_ms;
   logic [31:0]     sleep_since_ms;
   logic [31:0]     wake_since_ms;
   logic            beat_seen;
   logic            sleep_cond_held;
   logic            wake_armed;
   monitor_status_t status_due_q [$];

   // The spread test is the variance bound multiplied through by count squared.
   function automatic logic rates_fit_sleep();
      longint unsigned n, s, q, sq, lo, hi;
      n  = hist_fill;
      s  = rate_sum;
      q  = rate_sq_sum;
      lo = limits.sleep_rate_low;
      hi = limits.sleep_rate_high;
      if (n < MIN_FILLED) return 1'b0;
      if (s < lo * n || s > hi * n) return 1'b0;
      sq = s * s;
      if (n * q < sq) return 1'b1;
      return (n * q - sq) <= longint'(SPREAD_SQ) * n * n;
   endfunction

   task automatic classify_update(input logic [7:0] hr, input logic link,
                                  input logic present, input logic [15:0] lux,
                                  input logic [31:0] now_ms,
                                  output monitor_status_t res);
      int unsigned     old_rate;
      longint unsigned n, s, scaled, diff;
      logic [31:0]     span;
      logic            cond;

      if (hr != 8'd0) begin
         if (hist_fill >= HISTORY_DEPTH) begin
            old_rate    = rate_hist[hist_ptr];
            rate_sum    = rate_sum - old_rate;
            rate_sq_sum = rate_sq_sum - old_rate * old_rate;
         end else begin
            hist_fill++;
         end
         rate_hist[hist_ptr] = hr;
         rate_sum    = rate_sum + hr;
         rate_sq_sum = rate_sq_sum + int'(hr) * int'(hr);
         hist_ptr     = (hist_ptr == HISTORY_DEPTH - 1) ? 0 : hist_ptr + 1;
         last_beat_ms = now_ms;
         beat_seen    = 1'b1;
      end

      span = now_ms - last_beat_ms;
      if (link && hr != 8'd0) begin
         wear_state = WEAR_YES;
      end else if (!link) begin
         wear_state = WEAR_NO;
      end else if (!beat_seen) begin
         wear_state = WEAR_UNKNOWN;
      end else if (span >= LOST_TIMEOUT_MS || wear_state == WEAR_UNKNOWN) begin
         wear_state = WEAR_NO;
      end

      if (hr == 8'd0) begin
         heart_state = HEART_NORMAL;
      end else if (hr > limits.fast_rate_limit) begin
         heart_state = HEART_FAST;
      end else if (hr < limits.slow_rate_limit) begin
         heart_state = HEART_SLOW;
      end else begin
         heart_state = HEART_NORMAL;
         n = hist_fill;
         s = rate_sum;
         if (n >= MIN_FILLED && s > 0) begin
            scaled = longint'(hr) * n;
            diff   = (scaled >= s) ? scaled - s : s - scaled;
            if (diff * 100 > longint'(limits.deviation_percent) * s)
               heart_state = HEART_UNSTABLE;
         end
      end

      cond = present && (lux < limits.dark_lux_limit) && rates_fit_sleep();
      if (cond) begin
         if (!sleep_cond_held) begin
            sleep_cond_held = 1'b1;
            sleep_since_ms  = now_ms;
            wake_armed      = 1'b0;
         end
         span = now_ms - sleep_since_ms;
         if (sleep_state != SLEEP_ASLEEP && span >= limits.sleep_confirm_ms)
            sleep_state = SLEEP_ASLEEP;
      end else begin
         if (sleep_cond_held) begin
            sleep_cond_held = 1'b0;
            wake_since_ms   = now_ms;
            wake_armed      = 1'b1;
            sleep_since_ms  = '0;
         end
         if (sleep_state != SLEEP_AWAKE) begin
            span = wake_armed ? now_ms - wake_since_ms : 32'd0;
            if (span >= limits.wake_confirm_ms) sleep_state = SLEEP_AWAKE;
         end
      end

      res.wearing_flag  = (wear_state == WEAR_YES);
      res.sleeping_flag = (sleep_state == SLEEP_ASLEEP);
      res.heart_alert   = (heart_state != HEART_NORMAL);
      res.wear_code     = wear_state;
      res.sleep_code    = sleep_state;
      res.heart_code    = heart_state;
   endtask

   function automatic logic [31:0] limit_value(input logic [2:0] idx);
      case (idx)
         REG_FAST_RATE:     return 32'(limits.fast_rate_limit);
         REG_SLOW_RATE:     return 32'(limits.slow_rate_limit);
         REG_DEVIATION:     return 32'(limits.deviation_percent);
         REG_DARK_LUX:      return 32'(limits.dark_lux_limit);
         REG_SLEEP_LOW:     return 32'(limits.sleep_rate_low);
         REG_SLEEP_HIGH:    return 32'(limits.sleep_rate_high);
         REG_SLEEP_CONFIRM: return 32'(limits.sleep_confirm_ms);
         default:           return 32'(limits.wake_confirm_ms);
      endcase
   endfunction

   task automatic store_limit(input logic [2:0] idx, input logic [31:0] value);
      case (idx)
         REG_FAST_RATE:     limits.fast_rate_limit   = value[7:0];
         REG_SLOW_RATE:     limits.slow_rate_limit   = value[7:0];
         REG_DEVIATION:     limits.deviation_percent = value[DEV_W-1:0];
         REG_DARK_LUX:      limits.dark_lux_limit    = value[15:0];
         REG_SLEEP_LOW:     limits.sleep_rate_low    = value[7:0];
         REG_SLEEP_HIGH:    limits.sleep_rate_high   = value[7:0];
         REG_SLEEP_CONFIRM: limits.sleep_confirm_ms  = value[19:0];
         default:           limits.wake_confirm_ms   = value[19:0];
      endcase
   endtask

   task automatic check_field(input string name, input logic [1:0] want,
                              input logic [1:0] got);
      if (got !== want) begin
         $display("%0t: beat %0d %s mismatch, expected %0d, actual %0d",
                  $time, checked_beats, name, want, got);
         mismatch_count++;
      end
   endtask

   always @(posedge clock) begin
      monitor_status_t due;
      monitor_status_t fresh;
      if (reset) begin
         limits          = CFG_RESET;
         hist_ptr        = 0;
         hist_fill       = 0;
         rate_sum        = 0;
         rate_sq_sum     = 0;
         wear_state      = WEAR_UNKNOWN;
         sleep_state     = SLEEP_UNKNOWN;
         heart_state     = HEART_NORMAL;
         last_beat_ms    = '0;
         sleep_since_ms  = '0;
         wake_since_ms   = '0;
         beat_seen       = 1'b0;
         sleep_cond_held = 1'b0;
         wake_armed      = 1'b0;
         status_due_q.delete();
         mismatch_count  = 0;
         checked_beats   = 0;
         asleep_beats    = 0;
         unstable_beats  = 0;
         pending_beats  <= 0;
      end else begin
         if (csr_psel && csr_penable && csr_pready) begin
            if (csr_pwrite) begin
               store_limit(csr_paddr[CSR_ADDR_W-1:2], csr_pwdata);
            end else if (csr_prdata !== limit_value(csr_paddr[CSR_ADDR_W-1:2])) begin
               $display("%0t: register read at 0x%0h, expected 0x%0h, actual 0x%0h",
                        $time, csr_paddr, limit_value(csr_paddr[CSR_ADDR_W-1:2]),
                        csr_prdata);
               mismatch_count++;
            end
         end

         if (rsp_valid && rsp_ready) begin
            if (status_due_q.size() == 0) begin
               $display("%0t: result beat with nothing expected, actual wear %0d sleep %0d heart %0d",
                        $time, rsp_wear_code, rsp_sleep_code, rsp_heart_code);
               mismatch_count++;
            end else begin
               due = status_due_q.pop_front();
               check_field("wearing_flag", 2'(due.wearing_flag), 2'(rsp_wearing_flag));
               check_field("sleeping_flag", 2'(due.sleeping_flag), 2'(rsp_sleeping_flag));
               check_field("heart_alert", 2'(due.heart_alert), 2'(rsp_heart_alert));
               check_field("wear_code", due.wear_code, rsp_wear_code);
               check_field("sleep_code", due.sleep_code, rsp_sleep_code);
               check_field("heart_code", due.heart_code, rsp_heart_code);
               checked_beats++;
               if (due.sleep_code == SLEEP_ASLEEP) asleep_beats++;
               if (due.heart_code == HEART_UNSTABLE) unstable_beats++;
            end
         end

         if (req_valid && req_ready) begin
            classify_update(req_heart_rate, req_link_connected, req_human_present,
                            req_light_lux, req_now_ms, fresh);
            status_due_q.push_back(fresh);
         end

         pending_beats <= status_due_q.size();
      end
   end

endmodule

// File: test/wear_sleep_heart_rate_monitor_top_tb.sv
`timescale 1ns / 1ps

// Top of the monitor testbench. It only makes stimulus: sensor update beats,
// register programming and backpressure on the result side. All prediction
// and comparison lives in the checker instantiated beside the block.
module wear_sleep_heart_rate_monitor_top_tb;

   import wshrm_pkg::*;

   // Generous bound on the whole run, even with both sides idling at their longest.
   localparam int CYCLE_LIMIT  = 400000;
   localparam int PHASE_ITEMS  = 200;

   logic                  clock = 1'b0;
   logic                  reset = 1'b1;

   logic                  req_valid = 1'b0;
   logic                  req_ready;
   logic [7:0]            req_heart_rate = '0;
   logic                  req_link_connected = 1'b0;
   logic                  req_human_present = 1'b0;
   logic [15:0]           req_light_lux = '0;
   logic [31:0]           req_now_ms = '0;

   logic                  rsp_valid;
   logic                  rsp_ready = 1'b0;
   logic                  rsp_wearing_flag;
   logic                  rsp_sleeping_flag;
   logic                  rsp_heart_alert;
   logic [1:0]            rsp_wear_code;
   logic [1:0]            rsp_sleep_code;
   logic [1:0]            rsp_heart_code;

   logic                  csr_psel = 1'b0;
   logic                  csr_penable = 1'b0;
   logic                  csr_pwrite = 1'b0;
   logic [CSR_ADDR_W-1:0] csr_paddr = '0;
   logic [CSR_DATA_W-1:0] csr_pwdata = '0;
   logic [CSR_DATA_W-1:0] csr_prdata;
   logic                  csr_pready;

   int                    mismatch_count;
   int                    pending_beats;
   int                    checked_beats;
   int                    asleep_beats;
   int                    unstable_beats;

   // Stimulus bookkeeping. The sensor clock runs in the testbench and is put
   // on each update beat as it is sent.
   logic [31:0]           sensor_ms = '0;
   cfg_type               active_cfg = CFG_RESET;
   int                    req_idle_max = 0;
   int                    rsp_idle_max = 0;
   int                    updates_sent = 0;
   int                    settings_used = 1;
   int                    run_cycles = 0;

   initial begin
      forever #10 clock = ~clock;
   end

   wear_sleep_heart_rate_monitor_top i_dut (
      .clock              (clock),
      .reset              (reset),
      .req_valid          (req_valid),
      .req_ready          (req_ready),
      .req_heart_rate     (req_heart_rate),
      .req_link_connected (req_link_connected),
      .req_human_present  (req_human_present),
      .req_light_lux      (req_light_lux),
      .req_now_ms         (req_now_ms),
      .rsp_valid          (rsp_valid),
      .rsp_ready          (rsp_ready),
      .rsp_wearing_flag   (rsp_wearing_flag),
      .rsp_sleeping_flag  (rsp_sleeping_flag),
      .rsp_heart_alert    (rsp_heart_alert),
      .rsp_wear_code      (rsp_wear_code),
      .rsp_sleep_code     (rsp_sleep_code),
      .rsp_heart_code     (rsp_heart_code),
      .csr_psel           (csr_psel),
      .csr_penable        (csr_penable),
      .csr_pwrite         (csr_pwrite),
      .csr_paddr          (csr_paddr),
      .csr_pwdata         (csr_pwdata),
      .csr_prdata         (csr_prdata),
      .csr_pready         (csr_pready)
   );

   wshrm_status_checker i_checker (
      .clock              (clock),
      .reset              (reset),
      .req_valid          (req_valid),
      .req_ready          (req_ready),
      .req_heart_rate     (req_heart_rate),
      .req_link_connected (req_link_connected),
      .req_human_present  (req_human_present),
      .req_light_lux      (req_light_lux),
      .req_now_ms         (req_now_ms),
      .rsp_valid          (rsp_valid),
      .rsp_ready          (rsp_ready),
      .rsp_wearing_flag   (rsp_wearing_flag),
      .rsp_sleeping_flag  (rsp_sleeping_flag),
      .rsp_heart_alert    (rsp_heart_alert),
      .rsp_wear_code      (rsp_wear_code),
      .rsp_sleep_code     (rsp_sleep_code),
      .rsp_heart_code     (rsp_heart_code),
      .csr_psel           (csr_psel),
      .csr_penable        (csr_penable),
      .csr_pwrite         (csr_pwrite),
      .csr_paddr          (csr_paddr),
      .csr_pwdata         (csr_pwdata),
      .csr_prdata         (csr_prdata),
      .csr_pready         (csr_pready),
      .mismatch_count     (mismatch_count),
      .pending_beats      (pending_beats),
      .checked_beats      (checked_beats),
      .asleep_beats       (asleep_beats),
      .unstable_beats     (unstable_beats)
   );

   // Watchdog. A hung handshake or a lost result ends the run here.
   always @(posedge clock) begin
      run_cycles <= run_cycles + 1;
      if (run_cycles == CYCLE_LIMIT) begin
         $display("Timeout after %0d cycles with %0d results outstanding.",
                  run_cycles, pending_beats);
         $display("DONE: errors detected");
         $finish;
      end
   end

   // Each side draws a fresh wait for every beat. A maximum of zero gives a
   // stretch with no idling at all.
   function automatic int pick_gap(input int max_gap);
      return (max_gap == 0) ? 0 : int'($urandom_range(0, max_gap));
   endfunction

   function automatic int pick_pace();
      case ($urandom_range(0, 2))
         0:       return 0;
         1:       return 4;
         default: return 18;
      endcase
   endfunction

   task automatic choose_pace();
      req_idle_max = pick_pace();
      rsp_idle_max = pick_pace();
   endtask

   // Result side: draw a stall, hold ready low for it, then keep ready high
   // until one result beat has been taken.
   initial begin
      int stall;
      repeat (3) @(posedge clock);
      forever begin
         stall = pick_gap(rsp_idle_max);
         if (stall > 0) begin
            rsp_ready <= 1'b0;
            repeat (stall) @(posedge clock);
         end
         rsp_ready <= 1'b1;
         do @(posedge clock); while (!rsp_valid);
      end
   end

   // Sends one sensor update stamped with the current sensor time. The task
   // is entered at a clock edge and returns at the edge that took the beat,
   // so valid stays high across back-to-back beats.
   task automatic send_update(input int hr, input logic link, input logic present,
                              input int lux);
      int gap;
      gap = pick_gap(req_idle_max);
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid          <= 1'b1;
      req_heart_rate     <= 8'(hr);
      req_link_connected <= link;
      req_human_present  <= present;
      req_light_lux      <= 16'(lux);
      req_now_ms         <= sensor_ms;
      do @(posedge clock); while (!req_ready);
      updates_sent++;
   endtask

   // Lets every outstanding result drain. The first edge lets the checker
   // see a beat that was taken at the edge the caller returned on.
   task automatic wait_idle();
      req_valid <= 1'b0;
      @(posedge clock);
      while (pending_beats != 0) @(posedge clock);
      repeat (8) @(posedge clock);
   endtask

   // One register transfer: a setup phase, then an access phase that ends
   // when pready is seen, then an idle phase so select is never dropped and
   // raised in the same step.
   task automatic csr_transfer(input logic [2:0] idx, input logic wr,
                               input logic [31:0] data);
      csr_psel    <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite  <= wr;
      csr_paddr   <= {idx, 2'b00};
      csr_pwdata  <= data;
      @(posedge clock);
      csr_penable <= 1'b1;
      do @(posedge clock); while (!csr_pready);
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
      @(posedge clock);
   endtask

   // Writes a register and reads it straight back; the checker compares the
   // read data against its own copy of the limits.
   task automatic set_reg(input logic [2:0] idx, input logic [31:0] value);
      csr_transfer(idx, 1'b1, value);
      csr_transfer(idx, 1'b0, '0);
   endtask

   function automatic cfg_type make_limits(input int fast, input int slow, input int dev,
                                           input int dark, input int low, input int high,
                                           input int confirm, input int wake);
      cfg_type c;
      c.fast_rate_limit   = 8'(fast);
      c.slow_rate_limit   = 8'(slow);
      c.deviation_percent = DEV_W'(dev);
      c.dark_lux_limit    = 16'(dark);
      c.sleep_rate_low    = 8'(low);
      c.sleep_rate_high   = 8'(high);
      c.sleep_confirm_ms  = 20'(confirm);
      c.wake_confirm_ms   = 20'(wake);
      return c;
   endfunction

   // Registers change only with nothing in flight.
   task automatic apply_limits(input cfg_type c);
      wait_idle();
      set_reg(REG_FAST_RATE, 32'(c.fast_rate_limit));
      set_reg(REG_SLOW_RATE, 32'(c.slow_rate_limit));
      set_reg(REG_DEVIATION, 32'(c.deviation_percent));
      set_reg(REG_DARK_LUX, 32'(c.dark_lux_limit));
      set_reg(REG_SLEEP_LOW, 32'(c.sleep_rate_low));
      set_reg(REG_SLEEP_HIGH, 32'(c.sleep_rate_high));
      set_reg(REG_SLEEP_CONFIRM, 32'(c.sleep_confirm_ms));
      set_reg(REG_WAKE_CONFIRM, 32'(c.wake_confirm_ms));
      active_cfg = c;
      settings_used++;
   endtask

   // A well-formed night: steady rates inside the sleep band with a little
   // jitter, a person present in the dark, and time moving at about the
   // sensor rate with the odd long jump to get past the confirm timers.
   // Rare zero readings and spikes keep the heart and wake paths busy.
   task automatic sleep_session(input int len);
      int lo, hi, base, jitter, hr, lux, roll;
      lo = active_cfg.sleep_rate_low;
      hi = active_cfg.sleep_rate_high;
      if (lo < 1) lo = 1;
      if (hi < lo) hi = lo;
      base = $urandom_range(lo, hi);
      for (int i = 0; i < len; i++) begin
         roll = $urandom_range(0, 99);
         if (roll < 4) begin
            hr = 0;
         end else if (roll < 7) begin
            hr = $urandom_range(1, 255);
         end else begin
            jitter = $urandom_range(0, 4);
            hr = base + jitter - 2;
            if (hr < 1) hr = 1;
            if (hr > 255) hr = 255;
         end
         if (active_cfg.dark_lux_limit != 0 && $urandom_range(0, 19) != 0)
            lux = $urandom_range(0, int'(active_cfg.dark_lux_limit) - 1);
         else
            lux = $urandom_range(0, 65535);
         if ($urandom_range(0, 9) != 0)
            sensor_ms += $urandom_range(300, 700);
         else
            sensor_ms += $urandom_range(1000, 20000);
         send_update(hr, $urandom_range(0, 31) != 0, $urandom_range(0, 19) != 0, lux);
      end
   endtask

   // Unstructured updates, including wild jumps of the sensor clock that
   // wrap it and touch every bit of the timestamp.
   task automatic noise_burst(input int len);
      int hr, roll;
      for (int i = 0; i < len; i++) begin
         hr = ($urandom_range(0, 3) == 0) ? 0 : int'($urandom_range(0, 255));
         roll = $urandom_range(0, 9);
         if (roll < 7)
            sensor_ms += $urandom_range(0, 1000);
         else if (roll < 9)
            sensor_ms += $urandom_range(1000, 30000);
         else
            sensor_ms = $urandom;
         send_update(hr, 1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)),
                     $urandom_range(0, 65535));
      end
   endtask

   // Link up but no readings: walks the lost-beat timeout.
   task automatic beat_dropout(input int len);
      for (int i = 0; i < len; i++) begin
         sensor_ms += $urandom_range(1000, 6000);
         send_update(0, 1'b1, 1'($urandom_range(0, 1)), $urandom_range(0, 65535));
      end
   endtask

   task automatic run_traffic(input int quota);
      int done_items, len, kind;
      done_items = 0;
      while (done_items < quota) begin
         choose_pace();
         kind = $urandom_range(0, 99);
         if (kind < 60) begin
            len = $urandom_range(20, 60);
            sleep_session(len);
         end else if (kind < 85) begin
            len = $urandom_range(5, 20);
            noise_burst(len);
         end else begin
            len = $urandom_range(3, 10);
            beat_dropout(len);
         end
         done_items += len;
      end
   endtask

   // Directed opening at the reset limits: unknown wear before any beat,
   // link loss, a full sleep confirm followed by a wake, the lost-beat
   // timeout one millisecond short and exactly on time, the fast and slow
   // boundaries, an unstable spike, rate and light extremes, and a wrap of
   // the sensor clock.
   task automatic directed_updates();
      sensor_ms = 32'd0;
      send_update(0, 1'b1, 1'b0, 65535);
      sensor_ms = 32'd500;
      send_update(0, 1'b0, 1'b0, 0);
      for (int i = 0; i < 10; i++) begin
         sensor_ms += 2000;
         send_update(60 + i % 5, 1'b1, 1'b1, 0);
      end
      sensor_ms += 15000;
      send_update(62, 1'b1, 1'b1, 0);
      sensor_ms += 15000;
      send_update(62, 1'b1, 1'b1, 0);
      // A spike in bright light breaks the sleep condition and arms the wake timer.
      sensor_ms += 500;
      send_update(100, 1'b1, 1'b1, 20000);
      sensor_ms += 9999;
      send_update(0, 1'b1, 1'b1, 0);
      sensor_ms += 1;
      send_update(0, 1'b1, 1'b1, 0);
      sensor_ms += 5000;
      send_update(120, 1'b1, 1'b1, 0);
      sensor_ms += 500;
      send_update(121, 1'b1, 1'b1, 0);
      sensor_ms += 500;
      send_update(50, 1'b1, 1'b1, 0);
      sensor_ms += 500;
      send_update(49, 1'b1, 1'b1, 0);
      sensor_ms += 500;
      send_update(255, 1'b0, 1'b1, 65535);
      sensor_ms += 500;
      send_update(1, 1'b1, 1'b0, 0);
      sensor_ms = 32'hFFFF_FFFF;
      send_update(0, 1'b1, 1'b1, 0);
      sensor_ms += 8000;
      send_update(70, 1'b1, 1'b1, 0);
   endtask

   initial begin
      repeat (2) @(posedge clock);
      reset <= 1'b0;

      choose_pace();
      directed_updates();

      // Reset limits first, then the tight timers, both extremes, a fully
      // random setting (sleep band often inverted) and the reset values
      // written back explicitly.
      run_traffic(PHASE_ITEMS);
      apply_limits(make_limits(100, 55, $urandom_range(0, 100), 65535, 40, 90,
                               $urandom_range(0, 3000), $urandom_range(0, 3000)));
      run_traffic(PHASE_ITEMS);
      apply_limits(make_limits(0, 0, 0, 0, 0, 0, 0, 0));
      run_traffic(PHASE_ITEMS);
      apply_limits(make_limits(255, 255, 100, 65535, 255, 255, 600000, 600000));
      run_traffic(PHASE_ITEMS);
      apply_limits(make_limits($urandom_range(0, 255), $urandom_range(0, 255),
                               $urandom_range(0, 100), $urandom_range(0, 65535),
                               $urandom_range(0, 255), $urandom_range(0, 255),
                               $urandom_range(0, 600000), $urandom_range(0, 600000)));
      run_traffic(PHASE_ITEMS);
      apply_limits(CFG_RESET);
      run_traffic(PHASE_ITEMS);

      wait_idle();

      $display("Sent %0d sensor updates under %0d limit settings, directed edge cases first.",
               updates_sent, settings_used);
      $display("Checked %0d result beats, %0d of them asleep and %0d with an unstable rate.",
               checked_beats, asleep_beats, unstable_beats);
      if (mismatch_count == 0 && pending_beats == 0) begin
         $display("DONE: 0 errors");
      end else begin
         $display("DONE: errors detected");
      end
      $finish;
   end

endmodule
